FILE: rtl/core/ppmp6_pkg.sv
package ppmp6_pkg;

  localparam int unsigned TOKEN_MAX_BYTES = 15;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [15:0] VALUE_SAT = 16'hFFFF;
  localparam logic [15:0] MAXVAL_LIMIT = 16'd255;

  typedef enum logic [2:0] {
    PH_MAGIC0     = 3'd0,
    PH_MAGIC1_OK  = 3'd1,
    PH_MAGIC1_BAD = 3'd2,
    PH_GAP        = 3'd3,
    PH_TOKEN      = 3'd4,
    PH_COMMENT    = 3'd5,
    PH_PIXELS     = 3'd6,
    PH_HALT       = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_PIXEL       = 3'd0,
    EV_HEADER      = 3'd1,
    EV_BAD_MAGIC   = 3'd2,
    EV_TOKEN_LONG  = 3'd3,
    EV_MAXVAL_BIG  = 3'd4
  } event_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] token_value;
    logic [3:0]  token_length;
    logic        digits_ended;
    logic [1:0]  field_index;
    logic [15:0] width_held;
    logic [15:0] height_held;
    logic [1:0]  byte_in_pixel;
    logic [7:0]  red_held;
    logic [7:0]  green_held;
    logic [31:0] pixels_left;
  } state_t;

  typedef struct packed {
    event_t      event_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  max_value;
    logic        last_pixel;
  } result_t;

  typedef struct packed {
    logic        ended;
    logic [15:0] value;
  } token_acc_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_MAGIC0,
    token_value:   16'd0,
    token_length:  4'd0,
    digits_ended:  1'b0,
    field_index:   2'd0,
    width_held:    16'd0,
    height_held:   16'd0,
    byte_in_pixel: 2'd0,
    red_held:      8'd0,
    green_held:    8'd0,
    pixels_left:   32'd0
  };

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Folds one token byte into the running decimal value, saturating.
  function automatic token_acc_t take_char(input logic [15:0] value, input logic ended,
                                           input logic [7:0] b);
    token_acc_t  acc;
    logic [19:0] v;
    acc.ended = ended;
    acc.value = value;
    v = 20'(value) * 20'd10 + 20'(b[3:0]);
    if (!ended && b >= 8'h30 && b <= 8'h39) begin
      acc.value = (v > 20'(VALUE_SAT)) ? VALUE_SAT : v[15:0];
    end else begin
      acc.ended = 1'b1;
    end
    return acc;
  endfunction

endpackage

FILE: rtl/core/ppmp6_step.sv
module ppmp6_step (
  input  ppmp6_pkg::state_t  st,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output ppmp6_pkg::state_t  st_next,
  output logic               res_valid,
  output ppmp6_pkg::result_t res
);

  ppmp6_pkg::state_t     cur;
  ppmp6_pkg::token_acc_t acc_fresh;
  ppmp6_pkg::token_acc_t acc_cont;
  logic [31:0]           area;

  assign cur       = start_of_file ? ppmp6_pkg::STATE_RESET : st;
  assign acc_fresh = ppmp6_pkg::take_char(16'd0, 1'b0, data_byte);
  assign acc_cont  = ppmp6_pkg::take_char(cur.token_value, cur.digits_ended, data_byte);
  assign area      = 32'(cur.width_held) * 32'(cur.height_held);

  always_comb begin
    st_next          = cur;
    res_valid        = 1'b0;
    res.event_code   = ppmp6_pkg::EV_PIXEL;
    res.red          = 8'd0;
    res.green        = 8'd0;
    res.blue         = 8'd0;
    res.image_width  = 16'd0;
    res.image_height = 16'd0;
    res.max_value    = 8'd0;
    res.last_pixel   = 1'b0;

    unique case (cur.phase)
      ppmp6_pkg::PH_MAGIC0: begin
        st_next.phase = (data_byte == ppmp6_pkg::CH_P) ? ppmp6_pkg::PH_MAGIC1_OK
                                                        : ppmp6_pkg::PH_MAGIC1_BAD;
      end
      ppmp6_pkg::PH_MAGIC1_OK, ppmp6_pkg::PH_MAGIC1_BAD: begin
        if (cur.phase == ppmp6_pkg::PH_MAGIC1_OK && data_byte == ppmp6_pkg::CH_6) begin
          st_next.phase = ppmp6_pkg::PH_GAP;
        end else begin
          res_valid      = 1'b1;
          res.event_code = ppmp6_pkg::EV_BAD_MAGIC;
          st_next.phase  = ppmp6_pkg::PH_HALT;
        end
      end
      ppmp6_pkg::PH_GAP: begin
        if (data_byte == ppmp6_pkg::CH_HASH) begin
          st_next.phase = ppmp6_pkg::PH_COMMENT;
        end else if (!ppmp6_pkg::is_blank(data_byte)) begin
          st_next.token_value  = acc_fresh.value;
          st_next.digits_ended = acc_fresh.ended;
          st_next.token_length = 4'd1;
          st_next.phase        = ppmp6_pkg::PH_TOKEN;
        end
      end
      ppmp6_pkg::PH_COMMENT: begin
        if (data_byte == ppmp6_pkg::CH_LF) begin
          st_next.phase = ppmp6_pkg::PH_GAP;
        end
      end
      ppmp6_pkg::PH_TOKEN: begin
        if (!ppmp6_pkg::is_blank(data_byte)) begin
          if (cur.token_length >= 4'(ppmp6_pkg::TOKEN_MAX_BYTES)) begin
            res_valid      = 1'b1;
            res.event_code = ppmp6_pkg::EV_TOKEN_LONG;
            st_next.phase  = ppmp6_pkg::PH_HALT;
          end else begin
            st_next.token_length = cur.token_length + 4'd1;
            st_next.token_value  = acc_cont.value;
            st_next.digits_ended = acc_cont.ended;
          end
        end else begin
          st_next.phase = ppmp6_pkg::PH_GAP;
          // A zero token leaves the field unfilled, so the next token retries it.
          if (cur.token_value != 16'd0) begin
            if (cur.field_index == 2'd0) begin
              st_next.width_held  = cur.token_value;
              st_next.field_index = 2'd1;
            end else if (cur.field_index == 2'd1) begin
              st_next.height_held = cur.token_value;
              st_next.field_index = 2'd2;
            end else if (cur.token_value > ppmp6_pkg::MAXVAL_LIMIT) begin
              res_valid      = 1'b1;
              res.event_code = ppmp6_pkg::EV_MAXVAL_BIG;
              st_next.phase  = ppmp6_pkg::PH_HALT;
            end else begin
              res_valid             = 1'b1;
              res.event_code        = ppmp6_pkg::EV_HEADER;
              res.image_width       = cur.width_held;
              res.image_height      = cur.height_held;
              res.max_value         = cur.token_value[7:0];
              st_next.pixels_left   = area;
              st_next.byte_in_pixel = 2'd0;
              st_next.phase = (area != 32'd0) ? ppmp6_pkg::PH_PIXELS : ppmp6_pkg::PH_HALT;
            end
          end
        end
      end
      ppmp6_pkg::PH_PIXELS: begin
        if (cur.byte_in_pixel == 2'd0) begin
          st_next.red_held      = data_byte;
          st_next.byte_in_pixel = 2'd1;
        end else if (cur.byte_in_pixel == 2'd1) begin
          st_next.green_held    = data_byte;
          st_next.byte_in_pixel = 2'd2;
        end else begin
          st_next.byte_in_pixel = 2'd0;
          st_next.pixels_left   = cur.pixels_left - 32'd1;
          res_valid      = 1'b1;
          res.event_code = ppmp6_pkg::EV_PIXEL;
          res.red        = cur.red_held;
          res.green      = cur.green_held;
          res.blue       = data_byte;
          if (cur.pixels_left == 32'd1) begin
            res.last_pixel = 1'b1;
            st_next.phase  = ppmp6_pkg::PH_HALT;
          end
        end
      end
      ppmp6_pkg::PH_HALT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/ppm_p6_stream_parser_core.sv
// PPM (P6) stream parser: takes one file byte per clock and emits at most one
// result word per byte: a header word once width, height and maxval are read, then
// one word per RGB pixel with last_pixel on the final one, or an error word that
// halts the parser until a byte arrives with start_of_file set. Sustained rate is
// one byte per clock; a byte passes an input register, one pass through the parse
// step logic (whose longest path is the 16x16 width*height multiply taken on the
// byte that ends maxval) and the result register, which presents each result word
// and holds it until it is taken.
// Backpressure on the result side stalls the input.
module ppm_p6_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_code,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [7:0]  max_value,
  output logic        last_pixel
);

  logic               stall;
  logic               s0_valid;
  logic [7:0]         s0_byte;
  logic               s0_sof;
  ppmp6_pkg::state_t  st;
  ppmp6_pkg::state_t  st_next;
  logic               res_valid;
  ppmp6_pkg::result_t res;
  ppmp6_pkg::result_t out_res;

  assign stall    = out_valid && !out_ready;
  assign in_ready = !stall;

  ppmp6_step u_step (
    .st            (st),
    .data_byte     (s0_byte),
    .start_of_file (s0_sof),
    .st_next       (st_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ppmp6_pkg::STATE_RESET;
    end else if (!stall) begin
      s0_valid  <= in_valid;
      out_valid <= s0_valid && res_valid;
      if (s0_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s0_byte <= data_byte;
      s0_sof  <= start_of_file;
      out_res <= res;
    end
  end

  assign event_code   = out_res.event_code;
  assign red          = out_res.red;
  assign green        = out_res.green;
  assign blue         = out_res.blue;
  assign image_width  = out_res.image_width;
  assign image_height = out_res.image_height;
  assign max_value    = out_res.max_value;
  assign last_pixel   = out_res.last_pixel;

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> event_code == ppmp6_pkg::EV_PIXEL)
    else $error("last_pixel set on a word that is not a pixel");

  a_rgb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_code != ppmp6_pkg::EV_PIXEL |-> red == 8'd0 && green == 8'd0
      && blue == 8'd0)
    else $error("pixel samples nonzero on a non-pixel word");

  a_pixels_left: assert property (@(posedge clk) disable iff (rst)
    st.phase == ppmp6_pkg::PH_PIXELS |-> st.pixels_left != 32'd0)
    else $error("pixel phase with no pixels left");

  a_byte_slot: assert property (@(posedge clk) disable iff (rst)
    st.byte_in_pixel != 2'd3)
    else $error("byte position within pixel out of range");

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam int unsigned LIVE_BYTES_TARGET = 1900;
  localparam int unsigned WATCHDOG_LIMIT    = 5000;
  localparam int unsigned LONG_HOLD         = 400;
  localparam int unsigned SETTLE_CYCLES     = 6;
  localparam int unsigned MAX_REPORTS       = 10;

  class ppm_scoreboard;
    ppmp6_pkg::result_t expected_words[$];
    int unsigned failures;
    int unsigned headers_seen;
    int unsigned pixels_seen;
    int unsigned errors_seen;

    ppmp6_pkg::phase_t phase;
    logic [15:0] token_value;
    logic [3:0]  token_length;
    logic        digits_ended;
    logic [1:0]  field_index;
    logic [15:0] width_held;
    logic [15:0] height_held;
    logic [1:0]  byte_in_pixel;
    logic [7:0]  red_held;
    logic [7:0]  green_held;
    logic [31:0] pixels_left;

    function new();
      failures = 0;
      headers_seen = 0;
      pixels_seen = 0;
      errors_seen = 0;
      restart();
    endfunction

    static function bit blank_char(logic [7:0] b);
      return (b == ppmp6_pkg::CH_SPACE) ||
             (b >= ppmp6_pkg::CH_TAB && b <= ppmp6_pkg::CH_CR);
    endfunction

    function void restart();
      phase = ppmp6_pkg::PH_MAGIC0;
      token_value = '0;
      token_length = '0;
      digits_ended = 1'b0;
      field_index = '0;
      width_held = '0;
      height_held = '0;
      byte_in_pixel = '0;
      red_held = '0;
      green_held = '0;
      pixels_left = '0;
    endfunction

    // Decimal accumulation stops for good at the first non-digit of a token.
    function void take_digit(logic [7:0] b);
      int unsigned v;
      if (!digits_ended && b >= CH_ZERO && b <= CH_NINE) begin
        v = 32'(token_value) * 10 + 32'(b - CH_ZERO);
        token_value = (v > 32'(ppmp6_pkg::VALUE_SAT)) ? ppmp6_pkg::VALUE_SAT : v[15:0];
      end else begin
        digits_ended = 1'b1;
      end
    endfunction

    // Advances the parser by one accepted byte; returns 0 if the byte was ignored.
    function bit note_byte(logic [7:0] b, logic sof);
      ppmp6_pkg::result_t w;
      bit      emit;
      bit      live;
      w = '0;
      emit = 1'b0;
      live = sof || (phase != ppmp6_pkg::PH_HALT);
      if (sof) restart();
      case (phase)
        ppmp6_pkg::PH_MAGIC0: begin
          phase = (b == ppmp6_pkg::CH_P) ? ppmp6_pkg::PH_MAGIC1_OK
                                         : ppmp6_pkg::PH_MAGIC1_BAD;
        end
        ppmp6_pkg::PH_MAGIC1_OK, ppmp6_pkg::PH_MAGIC1_BAD: begin
          if (phase == ppmp6_pkg::PH_MAGIC1_OK && b == ppmp6_pkg::CH_6) begin
            phase = ppmp6_pkg::PH_GAP;
          end else begin
            w.event_code = ppmp6_pkg::EV_BAD_MAGIC;
            emit = 1'b1;
            phase = ppmp6_pkg::PH_HALT;
          end
        end
        ppmp6_pkg::PH_GAP: begin
          if (b == ppmp6_pkg::CH_HASH) begin
            phase = ppmp6_pkg::PH_COMMENT;
          end else if (!blank_char(b)) begin
            token_value = '0;
            digits_ended = 1'b0;
            token_length = 4'd1;
            take_digit(b);
            phase = ppmp6_pkg::PH_TOKEN;
          end
        end
        ppmp6_pkg::PH_COMMENT: begin
          if (b == ppmp6_pkg::CH_LF) phase = ppmp6_pkg::PH_GAP;
        end
        ppmp6_pkg::PH_TOKEN: begin
          if (!blank_char(b)) begin
            if (token_length >= ppmp6_pkg::TOKEN_MAX_BYTES) begin
              w.event_code = ppmp6_pkg::EV_TOKEN_LONG;
              emit = 1'b1;
              phase = ppmp6_pkg::PH_HALT;
            end else begin
              token_length = token_length + 4'd1;
              take_digit(b);
            end
          end else begin
            phase = ppmp6_pkg::PH_GAP;
            // A zero token leaves the field open for the next token.
            if (token_value == '0) begin
            end else if (field_index == 2'd0) begin
              width_held = token_value;
              field_index = 2'd1;
            end else if (field_index == 2'd1) begin
              height_held = token_value;
              field_index = 2'd2;
            end else if (token_value > ppmp6_pkg::MAXVAL_LIMIT) begin
              w.event_code = ppmp6_pkg::EV_MAXVAL_BIG;
              emit = 1'b1;
              phase = ppmp6_pkg::PH_HALT;
            end else begin
              w.event_code = ppmp6_pkg::EV_HEADER;
              w.image_width = width_held;
              w.image_height = height_held;
              w.max_value = token_value[7:0];
              emit = 1'b1;
              pixels_left = 32'(width_held) * 32'(height_held);
              byte_in_pixel = '0;
              phase = (pixels_left != '0) ? ppmp6_pkg::PH_PIXELS : ppmp6_pkg::PH_HALT;
            end
          end
        end
        ppmp6_pkg::PH_PIXELS: begin
          if (byte_in_pixel == 2'd0) begin
            red_held = b;
            byte_in_pixel = 2'd1;
          end else if (byte_in_pixel == 2'd1) begin
            green_held = b;
            byte_in_pixel = 2'd2;
          end else begin
            byte_in_pixel = '0;
            pixels_left = pixels_left - 32'd1;
            w.event_code = ppmp6_pkg::EV_PIXEL;
            w.red = red_held;
            w.green = green_held;
            w.blue = b;
            emit = 1'b1;
            if (pixels_left == '0) begin
              w.last_pixel = 1'b1;
              phase = ppmp6_pkg::PH_HALT;
            end
          end
        end
        default: begin
        end
      endcase
      if (emit) begin
        expected_words.push_back(w);
        if (w.event_code == ppmp6_pkg::EV_PIXEL) pixels_seen++;
        else if (w.event_code == ppmp6_pkg::EV_HEADER) headers_seen++;
        else errors_seen++;
      end
      return live;
    endfunction

    function void check_word(ppmp6_pkg::result_t got);
      ppmp6_pkg::result_t w;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result word ev=%0d with nothing expected", got.event_code);
        return;
      end
      w = expected_words.pop_front();
      if (got.event_code !== w.event_code || got.red !== w.red || got.green !== w.green ||
          got.blue !== w.blue || got.image_width !== w.image_width ||
          got.image_height !== w.image_height || got.max_value !== w.max_value ||
          got.last_pixel !== w.last_pixel) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch expected: ev=%0d rgb=%h,%h,%h dims=%0dx%0d max=%0d last=%b",
                   w.event_code, w.red, w.green, w.blue, w.image_width, w.image_height,
                   w.max_value, w.last_pixel);
          $display("         actual:   ev=%0d rgb=%h,%h,%h dims=%0dx%0d max=%0d last=%b",
                   got.event_code, got.red, got.green, got.blue, got.image_width,
                   got.image_height, got.max_value, got.last_pixel);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        start_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_code;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  max_value;
  logic        last_pixel;
  ppmp6_pkg::result_t got_word;

  ppm_scoreboard sb = new();

  logic [8:0]  stream_q[$];
  bit          sender_burst = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned burst_left = 0;
  int unsigned live_bytes = 0;
  int unsigned files_run = 0;
  int unsigned pauses = 0;
  int unsigned holds_done = 0;
  int unsigned idle_cycles = 0;

  ppm_p6_stream_parser_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .start_of_file(start_of_file),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_code(event_code),
    .red(red),
    .green(green),
    .blue(blue),
    .image_width(image_width),
    .image_height(image_height),
    .max_value(max_value),
    .last_pixel(last_pixel)
  );

  assign got_word = {event_code, red, green, blue, image_width, image_height, max_value,
                     last_pixel};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(got_word);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each word, stall-free stretches, and one
  // long hold-off whenever the stimulus asks for it.
  initial begin
    int unsigned n;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holds_done++;
        n = LONG_HOLD;
      end else if (burst_left != 0) begin
        burst_left--;
        n = 0;
      end else begin
        if ($urandom_range(0, 19) == 0) burst_left = 30;
        n = $urandom_range(0, 5);
      end
      repeat (n) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    start_of_file = sof;
    do @(posedge clk); while (!in_ready);
    if (sb.note_byte(b, sof)) live_bytes++;
  endtask

  task automatic play_file(input bit sof_first);
    logic [8:0] entry;
    bit         first;
    first = 1'b1;
    files_run++;
    while (stream_q.size() != 0) begin
      entry = stream_q.pop_front();
      send_byte(entry[7:0], entry[8] | (first & sof_first));
      first = 1'b0;
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    // Header and whitespace bytes give no word, so let the pipeline empty too.
    repeat (SETTLE_CYCLES) @(posedge clk);
    pauses++;
  endtask

  task automatic put(input logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put(s[i]);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 5))
      0: return ppmp6_pkg::CH_SPACE;
      1: return ppmp6_pkg::CH_TAB;
      2: return ppmp6_pkg::CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return ppmp6_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] any_solid(input bit no_digit, input bit no_hash);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (ppm_scoreboard::blank_char(b) || (no_digit && b >= CH_ZERO && b <= CH_NINE) ||
           (no_hash && b == ppmp6_pkg::CH_HASH));
    return b;
  endfunction

  task automatic put_gap();
    logic [7:0] b;
    put(any_blank());
    if ($urandom_range(0, 5) == 0) begin
      put(ppmp6_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        put((b == ppmp6_pkg::CH_LF) ? ppmp6_pkg::CH_SPACE : b);
      end
      put(ppmp6_pkg::CH_LF);
    end
    repeat ($urandom_range(0, 2)) put(any_blank());
  endtask

  task automatic put_number(input int unsigned v, input bit decorate);
    if (decorate && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) put(CH_ZERO);
    put_text($sformatf("%0d", v));
    if (decorate && $urandom_range(0, 4) == 0) begin
      put(any_solid(1'b1, 1'b0));
      if ($urandom_range(0, 1) == 1) put(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // Sometimes a zero-valued token comes first, so the field is read again.
  task automatic put_field(input int unsigned v);
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 2))
        0: put(CH_ZERO);
        1: put_text("000");
        default: begin
          put(any_solid(1'b1, 1'b1));
          put_number($urandom_range(0, 99), 1'b0);
        end
      endcase
      put_gap();
    end
    put_number(v, 1'b1);
  endtask

  task automatic build_image(input int unsigned w, input int unsigned h, input bit intact);
    int unsigned mv;
    int unsigned cut;
    case ($urandom_range(0, 9))
      0, 1:    mv = 255;
      2:       mv = 1;
      default: mv = $urandom_range(1, 255);
    endcase
    put_text("P6");
    put_gap();
    put_field(w);
    put_gap();
    put_field(h);
    put_gap();
    put_field(mv);
    put(any_blank());
    repeat (3 * w * h) put(8'($urandom_range(0, 255)));
    if (!intact && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    if (!intact && $urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, stream_q.size());
      stream_q = stream_q[0:cut-1];
    end
  endtask

  task automatic build_random_file(output bit sof_first);
    int unsigned kind;
    kind = $urandom_range(0, 99);
    sof_first = 1'b1;
    if (kind < 70) begin
      build_image(($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4),
                  $urandom_range(1, 3), 1'b0);
    end else if (kind < 77) begin
      if ($urandom_range(0, 1) == 1) begin
        put(ppmp6_pkg::CH_P);
        put(($urandom_range(0, 1) == 1) ? ppmp6_pkg::CH_P : 8'($urandom_range(0, 255)));
      end else begin
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
    end else if (kind < 84) begin
      // Tokens of 15 to 20 bytes: at the length limit or up to five bytes past it.
      put_text("P6");
      put_gap();
      put(any_solid(1'b0, 1'b1));
      repeat ($urandom_range(14, 19)) put(any_solid(1'b0, 1'b0));
      put_gap();
      put_text("1 1 255");
      put(ppmp6_pkg::CH_LF);
      repeat (3) put(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      put_text("P6");
      put_gap();
      put_field($urandom_range(1, 4));
      put_gap();
      put_field($urandom_range(1, 4));
      put_gap();
      put_number($urandom_range(256, 99999), 1'b0);
      put(any_blank());
      repeat (2) put(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      // A saturated width: a huge pixel count that the next file cuts short.
      put_text("P6 ");
      put_number($urandom_range(65535, 9999999), 1'b0);
      put_gap();
      put_number($urandom_range(1, 65535), 1'b0);
      put_text(" 200 ");
      repeat ($urandom_range(9, 30)) put(8'($urandom_range(0, 255)));
    end else begin
      sof_first = 1'($urandom_range(0, 1));
      repeat ($urandom_range(8, 24))
        stream_q.push_back({($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255))});
    end
  endtask

  initial begin
    bit sof_first;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset the first byte counts as magic without a start flag; then a
    // one-pixel image and a byte that the halted parser ignores.
    put_text("P6\t1\n1 255\n");
    put(8'hFF);
    put(8'h00);
    put(8'h80);
    put(8'h41);
    play_file(1'b0);
    put(ppmp6_pkg::CH_P);
    put(8'hFF);
    play_file(1'b1);
    // A zero width is read again, then the maxval is too large.
    put_text("P6 0 9 9 999 ");
    play_file(1'b1);
    pause_until_drained();

    while (live_bytes < LIVE_BYTES_TARGET) begin
      sender_burst = ($urandom_range(0, 4) == 0);
      if (files_run == 12 || files_run == 70) begin
        hold_request = 1'b1;
        sender_burst = 1'b1;
        build_image(4, 4, 1'b1);
        sof_first = 1'b1;
      end else begin
        build_random_file(sof_first);
      end
      play_file(sof_first);
      if (files_run % 40 == 0) pause_until_drained();
    end
    sender_burst = 1'b0;
    pause_until_drained();

    $display("Ran %0d file streams (%0d live bytes) with %0d drain pauses and %0d hold-offs.",
             files_run, live_bytes, pauses, holds_done);
    $display("Checked %0d header, %0d pixel and %0d error words.",
             sb.headers_seen, sb.pixels_seen, sb.errors_seen);
    if (sb.failures == 0 && sb.expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
